// File: design/mfbp_pkg.sv
// package for the msb-first bit packer: request and status codes, result struct
// and fixed widths shared by the engine and the top level
// no dependencies
`timescale 1ns / 1ps

package mfbp_pkg;

  localparam int unsigned AccW   = 64;
  localparam int unsigned OffW   = 20;
  localparam int unsigned CapW   = 17;
  localparam int unsigned LenW   = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned HeldW  = 6;
  localparam int unsigned ShiftW = 7;

  localparam logic [LenW-1:0]   MaxLen     = 8'd64;
  localparam logic [CapW-1:0]   CapReset   = 17'h10000;
  localparam logic [ShiftW-1:0] AccBits    = 7'd64;
  localparam logic [AccW-1:0]   AllOnes    = {AccW{1'b1}};

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_FLUSH   = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [AccW-1:0]  word;
    logic [CntW-1:0]  count;
    logic [AddrW-1:0] addr;
    status_e          status;
  } res_t;

endpackage

// File: design/mfbp_engine.sv
// packing engine: accumulator, held-bit count and stream offset, with the
// combinational shift, mask and merge that turns one request into one result
// depends on mfbp_pkg
`timescale 1ns / 1ps

module mfbp_engine #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mfbp_pkg::CapW-1:0]  capacity_i,
  input  logic                       fire_i,
  input  mfbp_pkg::req_e             req_i,
  input  logic [mfbp_pkg::AccW-1:0]  value_i,
  input  logic [mfbp_pkg::LenW-1:0]  length_i,
  output mfbp_pkg::res_t             result_o
);

  localparam int unsigned AddrKeep = (ADDR_BITS < mfbp_pkg::AddrW) ? ADDR_BITS : mfbp_pkg::AddrW;
  localparam logic [mfbp_pkg::AddrW-1:0] AddrMask =
    mfbp_pkg::AddrW'((33'd1 << AddrKeep) - 33'd1);

  logic [mfbp_pkg::AccW-1:0]  acc_q, acc_d;
  logic [mfbp_pkg::HeldW-1:0] held_q, held_d;
  logic [mfbp_pkg::OffW-1:0]  off_q, off_d;

  // shared terms
  logic [mfbp_pkg::ShiftW-1:0] n;
  logic [mfbp_pkg::AccW-1:0]   v_m;
  logic [mfbp_pkg::ShiftW:0]   sum;
  logic                        fill;
  logic [mfbp_pkg::ShiftW-1:0] t;
  logic [mfbp_pkg::HeldW-1:0]  r;
  logic [2:0]                  pad;
  logic [mfbp_pkg::OffW:0]     limit;
  logic                        fits_len;
  logic                        fits_pad;
  logic [mfbp_pkg::OffW-1:0]   start_bit;
  logic [mfbp_pkg::AddrW-1:0]  start_addr;
  logic [mfbp_pkg::ShiftW-1:0] b;

  always_comb begin
    n         = length_i[mfbp_pkg::ShiftW-1:0];
    v_m       = value_i & ~(mfbp_pkg::AllOnes << n);
    sum       = {2'b00, held_q} + {1'b0, n};
    fill      = (sum >= {1'b0, mfbp_pkg::AccBits});
    t         = mfbp_pkg::AccBits - {1'b0, held_q};
    r         = sum[mfbp_pkg::HeldW-1:0];
    pad       = 3'(3'd0 - held_q[2:0]);
    limit     = {1'b0, capacity_i, 3'b000};
    fits_len  = ({1'b0, off_q} + (mfbp_pkg::OffW+1)'(n)) <= limit;
    fits_pad  = ({1'b0, off_q} + (mfbp_pkg::OffW+1)'(pad)) <= limit;
    start_bit = off_q - mfbp_pkg::OffW'(held_q);
    start_addr = start_bit[mfbp_pkg::AddrW+2:3] & AddrMask;
    b         = {1'b0, held_q} + {4'b0000, pad};

    acc_d  = acc_q;
    held_d = held_q;
    off_d  = off_q;
    result_o.word   = '0;
    result_o.count  = '0;
    result_o.addr   = '0;
    result_o.status = mfbp_pkg::ST_OK;

    unique case (req_i)
      mfbp_pkg::REQ_WRITE: begin
        if (length_i > mfbp_pkg::MaxLen) begin
          result_o.status = mfbp_pkg::ST_BAD_LEN;
        end else if (n != '0) begin
          if (!fits_len) begin
            result_o.status = mfbp_pkg::ST_OVERFLOW;
          end else begin
            off_d = off_q + mfbp_pkg::OffW'(n);
            if (fill) begin
              // a full word leaves; the remainder starts the next one
              result_o.word  = (acc_q << t) | (v_m >> r);
              result_o.count = mfbp_pkg::CntW'(8);
              result_o.addr  = start_addr;
              acc_d  = v_m & ~(mfbp_pkg::AllOnes << r);
              held_d = r;
            end else begin
              acc_d  = (acc_q << n) | v_m;
              held_d = r;
            end
          end
        end
      end
      mfbp_pkg::REQ_FLUSH: begin
        if (held_q != '0) begin
          if (pad != '0 && !fits_pad) begin
            result_o.status = mfbp_pkg::ST_OVERFLOW;
          end else begin
            // padding is zeros, so left-aligning the held bits is enough
            result_o.word  = acc_q << t;
            result_o.count = b[mfbp_pkg::ShiftW-1:3];
            result_o.addr  = start_addr;
            acc_d  = '0;
            held_d = '0;
            off_d  = off_q + mfbp_pkg::OffW'(pad);
          end
        end
      end
      mfbp_pkg::REQ_RESTART: begin
        acc_d  = '0;
        held_d = '0;
        off_d  = '0;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      off_q  <= '0;
    end else if (fire_i) begin
      acc_q  <= acc_d;
      held_q <= held_d;
      off_q  <= off_d;
    end
  end

endmodule

// File: design/msb_first_bit_packer_top.sv
// top level of the msb-first bit packer: input register, capacity register,
// packing engine and result register with valid/stall handshakes
// depends on mfbp_pkg and mfbp_engine
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        sink       in_valid_i/in_stall_o  req_type_i, field_value_i, field_length_i
// out       source     out_valid_o/out_stall_i out_word_o, byte_count_o, byte_address_o, status_o
// cfg       sink       cfg_we_i               cfg_data_i (capacity in bytes)
//
// one transaction per cycle sustained while out_stall_i is low; a request goes from the
// input register to the result register, with the engine's shift/mask/merge between them
// each request yields exactly one result transaction
// reset clears the accumulator, held-bit count, stream offset and valids;
// capacity returns to 65536 bytes
// a stall on the result side holds the result; the input register then fills
// and in_stall_o rises only once both registers are occupied

module msb_first_bit_packer_top #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [mfbp_pkg::CapW-1:0]  cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [mfbp_pkg::AccW-1:0]  field_value_i,
  input  logic [mfbp_pkg::LenW-1:0]  field_length_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mfbp_pkg::AccW-1:0]  out_word_o,
  output logic [mfbp_pkg::CntW-1:0]  byte_count_o,
  output logic [mfbp_pkg::AddrW-1:0] byte_address_o,
  output logic [1:0]                 status_o
);

  // capacity register
  logic [mfbp_pkg::CapW-1:0] cap_q;

  // input register
  logic                      in_valid_q;
  logic [1:0]                req_q;
  logic [mfbp_pkg::AccW-1:0] value_q;
  logic [mfbp_pkg::LenW-1:0] length_q;

  // result register
  logic           out_valid_q;
  mfbp_pkg::res_t res_q;
  mfbp_pkg::res_t res_d;

  logic advance;
  logic in_accept;

  // the held request moves on whenever the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= mfbp_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= req_type_i;
      value_q  <= field_value_i;
      length_q <= field_length_i;
    end
  end

  mfbp_engine #(
    .ADDR_BITS(ADDR_BITS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .capacity_i(cap_q),
    .fire_i    (advance),
    .req_i     (mfbp_pkg::req_e'(req_q)),
    .value_i   (value_q),
    .length_i  (length_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_word_o     = res_q.word;
  assign byte_count_o   = res_q.count;
  assign byte_address_o = res_q.addr;
  assign status_o       = res_q.status;

endmodule
